/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PMCD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define PMCD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pmcd_pkg.sv */
// Shared types and constants for the pot-to-MIDI control change block.
package pmcd_pkg;

    // Channel counts per converter
    localparam int EXT_CHANNELS = 8;
    localparam int INT_CHANNELS = 4;
    localparam int TABLE_DEPTH  = EXT_CHANNELS + INT_CHANNELS;
    localparam int SLOT_W       = $clog2(TABLE_DEPTH);

    // Field widths
    localparam int CHAN_W      = 3;
    localparam int CHAN_CMP_W  = CHAN_W + 1;
    localparam int SAMPLE_W    = 12;
    localparam int CC_W        = 7;
    localparam int CHNUM_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int PROD_W      = SAMPLE_W + CC_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    // Scaling constants
    localparam int EXT_FULL_SCALE = 1023;
    localparam int INT_FULL_SCALE = 4095;
    localparam int EXT_SHIFT      = 10;
    localparam int INT_SHIFT      = 12;
    localparam logic [BYTE_W-1:0]  CC_STATUS   = 8'hB0;
    localparam logic [CHNUM_W-1:0] NIBBLE_MASK = 4'hF;

    // Message queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHAN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_CTRL_BASE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_CTRL_BASE  = 2'd3;

    // Live configuration
    typedef struct packed {
        logic [CHNUM_W-1:0] midi_chan;
        logic [CC_W-1:0]    change_threshold;
        logic [CC_W-1:0]    ext_controller_base;
        logic [CC_W-1:0]    int_controller_base;
    } cfg_t;

    // One pending control change
    typedef struct packed {
        logic [CC_W-1:0] controller;
        logic [CC_W-1:0] value;
    } msg_t;

endpackage

/* rtl/pmcd_if.sv */
// Channel interfaces: converter samples in, MIDI bytes out, register writes.
interface pmcd_pot_if;
    logic                         valid;
    logic                         ready;
    logic                         sample_source;
    logic [pmcd_pkg::CHAN_W-1:0]  chan_index;
    logic [pmcd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, sample_source, chan_index, sample, input ready);
    modport sink   (input valid, sample_source, chan_index, sample, output ready);
endinterface

interface pmcd_midi_if;
    logic                         valid;
    logic                         ready;
    logic [pmcd_pkg::BYTE_W-1:0]  midi_byte;
    logic                         last_byte;

    modport source (output valid, midi_byte, last_byte, input ready);
    modport sink   (input valid, midi_byte, last_byte, output ready);
endinterface

interface pmcd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pmcd_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [pmcd_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* rtl/pot_to_midi_cc_deadband_core.sv */
// Top level of the pot-to-MIDI control change block with dead band.
//
// Channels: pot takes one converter sample (sample_source, chan_index,
// sample) per transfer; midi delivers one byte per transfer, with last_byte
// set on the third byte of each control change; cfg writes one of four
// registers (midi channel, threshold, external and internal controller base).
// Path: a sample that changes its channel's value by more than the
// threshold passes stages s1 and s2, the message queue and the output
// byte register; its status byte is followed by controller and value bytes.
// Throughput: one sample per cycle unless a message waits on a full queue;
// each message holds the single-byte output port for its three bytes. A
// two-entry message queue lets the front end keep taking samples while
// the serializer drains.
// Samples for channels out of range, or within the dead band, give no bytes.
// Reset clears the per-channel table and loads the register defaults. When
// midi stalls the current byte holds, the queue fills, then pot.ready drops.
// Registers must be written only while the block is idle; it is not enforced.
module pot_to_midi_cc_deadband_core (
    input  logic         clk,
    input  logic         rst_n,
    pmcd_pot_if.sink     pot,
    pmcd_midi_if.source  midi,
    pmcd_cfg_if.sink     cfg
);

    pmcd_pkg::cfg_t  cfg_reg;
    logic            push_valid;
    logic            push_ready;
    pmcd_pkg::msg_t  push_msg;
    logic            pop_valid;
    logic            pop_ready;
    pmcd_pkg::msg_t  pop_msg;

    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.midi_chan           <= 4'd6;
            cfg_reg.change_threshold    <= 7'd3;
            cfg_reg.ext_controller_base <= 7'd1;
            cfg_reg.int_controller_base <= 7'd9;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                pmcd_pkg::REG_MIDI_CHAN:
                    cfg_reg.midi_chan <= cfg.wdata[pmcd_pkg::CHNUM_W-1:0];
                pmcd_pkg::REG_THRESHOLD:
                    cfg_reg.change_threshold <= cfg.wdata;
                pmcd_pkg::REG_EXT_CTRL_BASE:
                    cfg_reg.ext_controller_base <= cfg.wdata;
                pmcd_pkg::REG_INT_CTRL_BASE:
                    cfg_reg.int_controller_base <= cfg.wdata;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    pmcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pot        (pot),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_msg   (push_msg)
    );

    pmcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_msg   (push_msg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_msg    (pop_msg)
    );

    pmcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_msg    (pop_msg),
        .midi_chan  (cfg_reg.midi_chan),
        .midi       (midi)
    );

endmodule

/* rtl/pmcd_front.sv */
// Front end: accepts samples, scales them to 0..127 and applies the dead band.
module pmcd_front (
    input  logic            clk,
    input  logic            rst_n,
    pmcd_pot_if.sink        pot,
    input  pmcd_pkg::cfg_t  cfg,
    output logic            push_valid,
    input  logic            push_ready,
    output pmcd_pkg::msg_t  push_msg
);

    logic                          chan_ok;
    logic [pmcd_pkg::SAMPLE_W-1:0] clamped;
    logic [pmcd_pkg::PROD_W-1:0]   prod;
    logic [pmcd_pkg::SLOT_W-1:0]   slot_in;
    logic [pmcd_pkg::CC_W-1:0]     ctrl_in;

    logic                          s1_valid_reg;
    logic                          s1_src_reg;
    logic [pmcd_pkg::PROD_W-1:0]   s1_prod_reg;
    logic [pmcd_pkg::SLOT_W-1:0]   s1_slot_reg;
    logic [pmcd_pkg::CC_W-1:0]     s1_ctrl_reg;

    logic [pmcd_pkg::CC_W-1:0]     q0;
    logic [pmcd_pkg::PROD_W-1:0]   q_base;
    logic [pmcd_pkg::PROD_W-1:0]   rem;
    logic                          round_up;
    logic [pmcd_pkg::CC_W-1:0]     cc_next;

    logic                          s2_valid_reg;
    logic [pmcd_pkg::SLOT_W-1:0]   s2_slot_reg;
    logic [pmcd_pkg::CC_W-1:0]     s2_ctrl_reg;
    logic [pmcd_pkg::CC_W-1:0]     s2_cc_reg;

    logic [pmcd_pkg::CC_W-1:0]     sent_reg [pmcd_pkg::TABLE_DEPTH];
    logic [pmcd_pkg::CC_W-1:0]     prev;
    logic [pmcd_pkg::CC_W-1:0]     diff;
    logic                          send;
    logic                          adv;

    // Channel check, table slot and controller number
    always_comb
    begin
        if (pot.sample_source)
        begin
            chan_ok = {1'b0, pot.chan_index} <
                      pmcd_pkg::CHAN_CMP_W'(pmcd_pkg::INT_CHANNELS);
            slot_in = pmcd_pkg::SLOT_W'(pmcd_pkg::EXT_CHANNELS) +
                      pmcd_pkg::SLOT_W'(pot.chan_index);
            ctrl_in = cfg.int_controller_base + pmcd_pkg::CC_W'(pot.chan_index);
        end
        else
        begin
            chan_ok = {1'b0, pot.chan_index} <
                      pmcd_pkg::CHAN_CMP_W'(pmcd_pkg::EXT_CHANNELS);
            slot_in = pmcd_pkg::SLOT_W'(pot.chan_index);
            ctrl_in = cfg.ext_controller_base + pmcd_pkg::CC_W'(pot.chan_index);
        end
    end

    // Clamp and multiply by 127 as shift-subtract
    always_comb
    begin
        if (!pot.sample_source &&
            pot.sample > pmcd_pkg::SAMPLE_W'(pmcd_pkg::EXT_FULL_SCALE))
            clamped = pmcd_pkg::SAMPLE_W'(pmcd_pkg::EXT_FULL_SCALE);
        else
            clamped = pot.sample;
        prod = {clamped, {pmcd_pkg::CC_W{1'b0}}} - pmcd_pkg::PROD_W'(clamped);
    end

    // Divide by 2^n - 1: quotient estimate from the shift, one correction step
    always_comb
    begin
        if (s1_src_reg)
        begin
            q0       = pmcd_pkg::CC_W'(s1_prod_reg >> pmcd_pkg::INT_SHIFT);
            q_base   = (pmcd_pkg::PROD_W'(q0) << pmcd_pkg::INT_SHIFT) -
                       pmcd_pkg::PROD_W'(q0);
            rem      = s1_prod_reg - q_base;
            round_up = rem >= pmcd_pkg::PROD_W'(pmcd_pkg::INT_FULL_SCALE);
        end
        else
        begin
            q0       = pmcd_pkg::CC_W'(s1_prod_reg >> pmcd_pkg::EXT_SHIFT);
            q_base   = (pmcd_pkg::PROD_W'(q0) << pmcd_pkg::EXT_SHIFT) -
                       pmcd_pkg::PROD_W'(q0);
            rem      = s1_prod_reg - q_base;
            round_up = rem >= pmcd_pkg::PROD_W'(pmcd_pkg::EXT_FULL_SCALE);
        end
        cc_next = q0 + pmcd_pkg::CC_W'(round_up);
    end

    // Dead band compare against the last value sent
    always_comb
    begin
        prev = sent_reg[s2_slot_reg];
        if (s2_cc_reg > prev)
            diff = s2_cc_reg - prev;
        else
            diff = prev - s2_cc_reg;
        send = s2_valid_reg && (diff > cfg.change_threshold);
    end

    // Pipeline moves unless a message waits on a full queue
    assign adv                 = !send || push_ready;
    assign pot.ready           = adv;
    assign push_valid          = send;
    assign push_msg.controller = s2_ctrl_reg;
    assign push_msg.value      = s2_cc_reg;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pot.valid && chan_ok;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_src_reg  <= pot.sample_source;
            s1_prod_reg <= prod;
            s1_slot_reg <= slot_in;
            s1_ctrl_reg <= ctrl_in;
            s2_slot_reg <= s1_slot_reg;
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_cc_reg   <= cc_next;
        end
    end

    // Last value sent per channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pmcd_pkg::TABLE_DEPTH; i++)
                sent_reg[i] <= '0;
        end
        else if (send && push_ready)
        begin
            sent_reg[s2_slot_reg] <= s2_cc_reg;
        end
    end

endmodule

/* rtl/pmcd_queue.sv */
// Small message queue between the front end and the byte serializer.
module pmcd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  pmcd_pkg::msg_t  push_msg,
    output logic            pop_valid,
    input  logic            pop_ready,
    output pmcd_pkg::msg_t  pop_msg
);

    pmcd_pkg::msg_t              entries [pmcd_pkg::QUEUE_DEPTH];
    logic [pmcd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [pmcd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [pmcd_pkg::QCNT_W-1:0] count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = count_reg != pmcd_pkg::QCNT_W'(pmcd_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_msg    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                if (wr_ptr_reg == pmcd_pkg::QPTR_W'(pmcd_pkg::QUEUE_DEPTH - 1))
                    wr_ptr_reg <= '0;
                else
                    wr_ptr_reg <= wr_ptr_reg + pmcd_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                if (rd_ptr_reg == pmcd_pkg::QPTR_W'(pmcd_pkg::QUEUE_DEPTH - 1))
                    rd_ptr_reg <= '0;
                else
                    rd_ptr_reg <= rd_ptr_reg + pmcd_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop)
                count_reg <= count_reg + pmcd_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - pmcd_pkg::QCNT_W'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_msg;
    end

endmodule

/* rtl/pmcd_back.sv */
// Back end: turns each queued message into three MIDI bytes.
module pmcd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  pmcd_pkg::msg_t                pop_msg,
    input  logic [pmcd_pkg::CHNUM_W-1:0]  midi_chan,
    pmcd_midi_if.source                   midi
);

    typedef enum logic [2:0] {
        PH_STATUS = 3'b001,
        PH_CTRL   = 3'b010,
        PH_VALUE  = 3'b100
    } phase_t;

    phase_t                      phase_reg;
    phase_t                      phase_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [pmcd_pkg::BYTE_W-1:0] out_byte_reg;
    logic [pmcd_pkg::BYTE_W-1:0] out_byte_next;
    logic                        out_last_reg;
    logic                        out_last_next;
    pmcd_pkg::msg_t              hold_reg;
    pmcd_pkg::msg_t              hold_next;
    logic                        load;

    // Output register takes a new byte when empty or being taken
    assign load = !out_valid_reg || midi.ready;

    // Byte sequencer
    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        hold_next      = hold_reg;
        pop_ready      = 1'b0;
        case (phase_reg)
            PH_STATUS:
            begin
                pop_ready = load;
                if (load)
                begin
                    out_valid_next = pop_valid;
                    if (pop_valid)
                    begin
                        out_byte_next = pmcd_pkg::CC_STATUS |
                                        {4'b0, midi_chan & pmcd_pkg::NIBBLE_MASK};
                        out_last_next = 1'b0;
                        hold_next     = pop_msg;
                        phase_next    = PH_CTRL;
                    end
                end
            end
            PH_CTRL:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {1'b0, hold_reg.controller};
                    out_last_next  = 1'b0;
                    phase_next     = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {1'b0, hold_reg.value};
                    out_last_next  = 1'b1;
                    phase_next     = PH_STATUS;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
                phase_next     = PH_STATUS;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_STATUS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        hold_reg     <= hold_next;
    end

    assign midi.valid     = out_valid_reg;
    assign midi.midi_byte = out_byte_reg;
    assign midi.last_byte = out_last_reg;

endmodule

/* rtl/pmcd_checker.sv */
// Port-level checks on the MIDI byte stream, bound to the top level.
`include "assert_macros.svh"

module pmcd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          midi_valid,
    input logic                          midi_ready,
    input logic [pmcd_pkg::BYTE_W-1:0]   midi_byte,
    input logic                          last_byte
);

    logic xfer;

    assign xfer = midi_valid && midi_ready;

    `PMCD_ASSERT_ALWAYS(a_no_valid_in_reset, clk, !rst_n |-> !midi_valid, "byte offered during reset")
    `PMCD_ASSERT(a_valid_holds, clk, rst_n, midi_valid && !midi_ready |=> midi_valid, "stalled byte withdrawn")
    `PMCD_ASSERT(a_last_is_data, clk, rst_n, midi_valid && last_byte |-> !midi_byte[7], "final byte has bit 7 set")
    `PMCD_ASSERT(a_status_form, clk, rst_n, midi_valid && midi_byte[7] |-> midi_byte[7:4] == 4'hB && !last_byte, "bad status byte")
    `PMCD_ASSERT(a_no_double_last, clk, rst_n, xfer && last_byte |=> !(xfer && last_byte), "two final bytes in a row")

endmodule

bind pot_to_midi_cc_deadband_core pmcd_checker u_pmcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .midi_valid (midi.valid),
    .midi_ready (midi.ready),
    .midi_byte  (midi.midi_byte),
    .last_byte  (midi.last_byte)
);

/* sim/tb_pot_to_midi_cc_deadband_core.sv */
// Self-checking testbench for the pot-to-MIDI control change core with dead band.
`timescale 1ns / 1ps

module tb_pot_to_midi_cc_deadband_core;

    localparam int CC_MAX       = 127;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 160;
    localparam int HOLD_LEN     = 120;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 90;

    typedef struct {
        logic                          src;
        logic [pmcd_pkg::CHAN_W-1:0]   chan;
        logic [pmcd_pkg::SAMPLE_W-1:0] sample;
    } pot_item_t;

    typedef struct {
        logic [pmcd_pkg::BYTE_W-1:0] midi_byte;
        logic                        last_byte;
    } midi_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    pmcd_pot_if  pot_ch ();
    pmcd_midi_if midi_ch ();
    pmcd_cfg_if  cfg_ch ();

    pot_to_midi_cc_deadband_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pot   (pot_ch),
        .midi  (midi_ch),
        .cfg   (cfg_ch)
    );

    pot_item_t                 sample_queue[$];
    midi_out_t                 cc_bytes_due[$];
    pmcd_pkg::cfg_t            cfg_shadow;
    logic [pmcd_pkg::CC_W-1:0] sent_cc [pmcd_pkg::TABLE_DEPTH];
    int                        walk_sample [pmcd_pkg::TABLE_DEPTH];
    int                        mismatches = 0;
    int                        samples_taken;
    int                        hold_left;
    bit                        hold_done;
    bit                        gaps_on = 1'b1;

    always #5 clk = ~clk;

    // Scale a raw reading to 0..127, clamping external readings at full scale
    function automatic int scale_to_cc(logic src, logic [pmcd_pkg::SAMPLE_W-1:0] raw);
        int v;
        v = int'(raw);
        if (src)
            return (v * CC_MAX) / pmcd_pkg::INT_FULL_SCALE;
        if (v > pmcd_pkg::EXT_FULL_SCALE)
            v = pmcd_pkg::EXT_FULL_SCALE;
        return (v * CC_MAX) / pmcd_pkg::EXT_FULL_SCALE;
    endfunction

    // Work out the control change bytes one sample causes and update the table
    function void predict_cc_message(pot_item_t it);
        int                        slot;
        int                        cc;
        int                        prev;
        int                        diff;
        logic [pmcd_pkg::CC_W-1:0] ctrl;
        midi_out_t                 b;
        if (it.src)
        begin
            if (it.chan >= pmcd_pkg::INT_CHANNELS)
                return;
            slot = pmcd_pkg::EXT_CHANNELS + int'(it.chan);
            ctrl = cfg_shadow.int_controller_base + pmcd_pkg::CC_W'(it.chan);
        end
        else
        begin
            if (it.chan >= pmcd_pkg::EXT_CHANNELS)
                return;
            slot = int'(it.chan);
            ctrl = cfg_shadow.ext_controller_base + pmcd_pkg::CC_W'(it.chan);
        end
        cc   = scale_to_cc(it.src, it.sample);
        prev = int'(sent_cc[slot]);
        diff = (cc > prev) ? cc - prev : prev - cc;
        if (diff <= int'(cfg_shadow.change_threshold))
            return;
        b.midi_byte = pmcd_pkg::CC_STATUS | {4'h0, cfg_shadow.midi_chan};
        b.last_byte = 1'b0;
        cc_bytes_due.push_back(b);
        b.midi_byte = {1'b0, ctrl};
        cc_bytes_due.push_back(b);
        b.midi_byte = {1'b0, pmcd_pkg::CC_W'(cc)};
        b.last_byte = 1'b1;
        cc_bytes_due.push_back(b);
        sent_cc[slot] = pmcd_pkg::CC_W'(cc);
    endfunction

    function void add_sample(bit src, int ch, int smp);
        pot_item_t it;
        it.src    = src;
        it.chan   = ch[pmcd_pkg::CHAN_W-1:0];
        it.sample = smp[pmcd_pkg::SAMPLE_W-1:0];
        sample_queue.push_back(it);
    endfunction

    // Mostly small walks around each channel's last reading, some full-range jumps
    function automatic pot_item_t random_item();
        pot_item_t it;
        int        slot;
        int        walk;
        it.src = 1'($urandom_range(1));
        if ($urandom_range(19) == 0)
            it.chan = pmcd_pkg::CHAN_W'($urandom_range(7));
        else if (it.src)
            it.chan = pmcd_pkg::CHAN_W'($urandom_range(pmcd_pkg::INT_CHANNELS - 1));
        else
            it.chan = pmcd_pkg::CHAN_W'($urandom_range(pmcd_pkg::EXT_CHANNELS - 1));
        if ($urandom_range(9) < 4)
        begin
            it.sample = pmcd_pkg::SAMPLE_W'($urandom_range(4095));
        end
        else
        begin
            slot = it.src ? pmcd_pkg::EXT_CHANNELS + int'(it.chan) : int'(it.chan);
            if (slot >= pmcd_pkg::TABLE_DEPTH)
                slot = 0;
            walk = int'($urandom_range(160));
            walk = walk - 80;
            if (it.src)
                walk = walk * 4;
            walk = walk_sample[slot] + walk;
            if (walk < 0)
                walk = 0;
            if (it.src && walk > 4095)
                walk = 4095;
            if (!it.src && walk > 1100)
                walk = 1100;
            walk_sample[slot] = walk;
            it.sample = pmcd_pkg::SAMPLE_W'(walk);
        end
        return it;
    endfunction

    // Sample driver: next item after each transfer, random gaps
    always @(posedge clk or negedge rst_n)
    begin : pot_drive
        pot_item_t nxt;
        if (!rst_n)
        begin
            pot_ch.valid         <= 1'b0;
            pot_ch.sample_source <= 1'b0;
            pot_ch.chan_index    <= '0;
            pot_ch.sample        <= '0;
        end
        else if (!pot_ch.valid || pot_ch.ready)
        begin
            if (sample_queue.size() != 0 && !(gaps_on && $urandom_range(99) < 9))
            begin
                nxt = sample_queue.pop_front();
                pot_ch.sample_source <= nxt.src;
                pot_ch.chan_index    <= nxt.chan;
                pot_ch.sample        <= nxt.sample;
                pot_ch.valid         <= 1'b1;
            end
            else
            begin
                pot_ch.valid <= 1'b0;
            end
        end
    end

    // MIDI receiver: random stalls plus one long hold-off to back up the queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midi_ch.ready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            midi_ch.ready <= 1'b0;
        end
        else if (!hold_done && samples_taken >= HOLD_AT)
        begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_LEN;
            midi_ch.ready <= 1'b0;
        end
        else
        begin
            midi_ch.ready <= !(gaps_on && $urandom_range(99) < 9);
        end
    end

    // Monitor: track register writes, predict on sample transfers, check bytes
    always @(posedge clk or negedge rst_n)
    begin : monitor
        midi_out_t want;
        pot_item_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < pmcd_pkg::TABLE_DEPTH; k++)
                sent_cc[k] = '0;
            cfg_shadow.midi_chan           = 4'd6;
            cfg_shadow.change_threshold    = 7'd3;
            cfg_shadow.ext_controller_base = 7'd1;
            cfg_shadow.int_controller_base = 7'd9;
            samples_taken <= 0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.reg_index)
                    pmcd_pkg::REG_MIDI_CHAN:
                        cfg_shadow.midi_chan = cfg_ch.wdata[pmcd_pkg::CHNUM_W-1:0];
                    pmcd_pkg::REG_THRESHOLD:
                        cfg_shadow.change_threshold = cfg_ch.wdata;
                    pmcd_pkg::REG_EXT_CTRL_BASE:
                        cfg_shadow.ext_controller_base = cfg_ch.wdata;
                    pmcd_pkg::REG_INT_CTRL_BASE:
                        cfg_shadow.int_controller_base = cfg_ch.wdata;
                    default: ;
                endcase
            end
            if (midi_ch.valid && midi_ch.ready)
            begin
                if (cc_bytes_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected MIDI byte %02h last=%0b", $realtime,
                                 midi_ch.midi_byte, midi_ch.last_byte);
                end
                else
                begin
                    want = cc_bytes_due.pop_front();
                    if (want.midi_byte !== midi_ch.midi_byte
                            || want.last_byte !== midi_ch.last_byte)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: MIDI byte exp %02h last=%0b, got %02h last=%0b",
                                     $realtime, want.midi_byte, want.last_byte,
                                     midi_ch.midi_byte, midi_ch.last_byte);
                    end
                end
            end
            if (pot_ch.valid && pot_ch.ready)
            begin
                got.src    = pot_ch.sample_source;
                got.chan   = pot_ch.chan_index;
                got.sample = pot_ch.sample;
                predict_cc_message(got);
                samples_taken <= samples_taken + 1;
            end
        end
    end

    // One register write over the config channel
    task automatic write_reg(logic [pmcd_pkg::CFG_IDX_W-1:0] idx, int val);
        @(posedge clk);
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= val[pmcd_pkg::CFG_DATA_W-1:0];
        cfg_ch.valid     <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Sender holds until every queued sample is taken and every byte is in
    task automatic wait_idle();
        while (sample_queue.size() != 0 || pot_ch.valid || cc_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = pmcd_pkg::REG_MIDI_CHAN;
        cfg_ch.wdata     = '0;
        #1;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: dead band edge, clamping, ignored channels, all-bit patterns
        @(negedge clk);
        add_sample(0, 0, 0);
        add_sample(0, 0, 12'hFFF);
        add_sample(0, 0, 1024);
        add_sample(0, 1, 25);
        add_sample(0, 1, 33);
        add_sample(0, 7, 1023);
        add_sample(1, 3, 4095);
        add_sample(1, 0, 12'hAAA);
        add_sample(1, 1, 12'h555);
        add_sample(1, 4, 4095);
        add_sample(1, 7, 0);
        add_sample(0, 2, 12'h3FF);
        add_sample(0, 2, 12'h3F0);
        wait_idle();

        // Top channel, zero threshold, controller numbers that wrap
        write_reg(pmcd_pkg::REG_MIDI_CHAN, 15);
        write_reg(pmcd_pkg::REG_THRESHOLD, 0);
        write_reg(pmcd_pkg::REG_EXT_CTRL_BASE, 127);
        write_reg(pmcd_pkg::REG_INT_CTRL_BASE, 127);
        @(negedge clk);
        add_sample(0, 7, 0);
        add_sample(1, 3, 0);
        add_sample(0, 5, 9);
        add_sample(0, 5, 9);
        add_sample(1, 2, 33);
        wait_idle();

        // Largest threshold: even a full swing stays inside the dead band
        write_reg(pmcd_pkg::REG_MIDI_CHAN, 0);
        write_reg(pmcd_pkg::REG_THRESHOLD, 127);
        write_reg(pmcd_pkg::REG_EXT_CTRL_BASE, 0);
        write_reg(pmcd_pkg::REG_INT_CTRL_BASE, 0);
        @(negedge clk);
        add_sample(0, 0, 0);
        add_sample(1, 0, 4095);
        wait_idle();

        // Random phases, each with its own register settings; one without gaps
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            write_reg(pmcd_pkg::REG_MIDI_CHAN, $urandom_range(15));
            write_reg(pmcd_pkg::REG_THRESHOLD,
                      ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(8));
            write_reg(pmcd_pkg::REG_EXT_CTRL_BASE, $urandom_range(127));
            write_reg(pmcd_pkg::REG_INT_CTRL_BASE, $urandom_range(127));
            gaps_on <= (ph != 2);
            @(negedge clk);
            for (int k = 0; k < PHASE_ITEMS; k++)
                sample_queue.push_back(random_item());
            wait_idle();
        end

        if (mismatches == 0 && cc_bytes_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
